// ===== hw/rtl/qrsbd_pkg.sv =====
// ----------------------------------------------------------------------------
// qrsbd_pkg
// Shared widths, register indexes and the queue entry type of the quarter
// rate shift and boxcar decimator.
// ----------------------------------------------------------------------------
package qrsbd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ROT_W    = SAMPLE_W + 1;  // negated full-scale needs one more bit
  localparam int unsigned ACC_W    = ROT_W + 2;     // sum of up to four rotated samples
  localparam int unsigned BITS_W   = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = BITS_W;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_SEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_SEL    = 2'd2;

  localparam logic [BITS_W-1:0] SAMPLE_BITS_RST = 5'd16;
  localparam logic [BITS_W-1:0] LIM_X2 = 5'd15;
  localparam logic [BITS_W-1:0] LIM_X4 = 5'd14;
  localparam logic [BITS_W-1:0] LOG2_X2 = 5'd1;
  localparam logic [BITS_W-1:0] LOG2_X4 = 5'd2;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned IN_TDATA_W  = 2 * SAMPLE_W;
  localparam int unsigned OUT_FIELD_W = 2 * SAMPLE_W + BITS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // One classified sample on its way from the front end to the accumulator.
  typedef struct packed {
    logic signed [ROT_W-1:0] rot_i;
    logic signed [ROT_W-1:0] rot_q;
    logic                    emit;
    logic [BITS_W-1:0]       shift;
    logic [BITS_W-1:0]       out_bits;
  } entry_t;

endpackage

// ===== hw/rtl/qrsbd_front.sv =====
// ----------------------------------------------------------------------------
// qrsbd_front
// Holds configuration, tracks the phase, rotates each sample by a power of j
// and marks the samples that close a decimation group.
// ----------------------------------------------------------------------------
module qrsbd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qrsbd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [qrsbd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [qrsbd_pkg::SAMPLE_W-1:0] in_i_i,
  input  logic signed [qrsbd_pkg::SAMPLE_W-1:0] in_q_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output qrsbd_pkg::entry_t                 push_entry_o
);

  logic [qrsbd_pkg::BITS_W-1:0] sample_bits_q;
  logic                         factor_sel_q;
  logic                         band_sel_q;
  logic [1:0]                   phase_q;
  logic [1:0]                   phase_d;
  logic [1:0]                   k;
  logic                         accept;
  logic signed [qrsbd_pkg::ROT_W-1:0] ri, rq;
  logic [qrsbd_pkg::BITS_W-1:0] lim, lg, sh;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i & push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bits_q <= qrsbd_pkg::SAMPLE_BITS_RST;
      factor_sel_q  <= 1'b0;
      band_sel_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        qrsbd_pkg::REG_SAMPLE_BITS: sample_bits_q <= cfg_data_i;
        qrsbd_pkg::REG_FACTOR_SEL:  factor_sel_q  <= cfg_data_i[0];
        qrsbd_pkg::REG_BAND_SEL:    band_sel_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign phase_d = accept ? phase_q + 2'd1 : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // High band rotates by (-j)^(n+1), which is j^(3-n).
  assign k  = band_sel_q ? ~phase_q : phase_q;
  assign ri = qrsbd_pkg::ROT_W'(in_i_i);
  assign rq = qrsbd_pkg::ROT_W'(in_q_i);

  assign lim = factor_sel_q ? qrsbd_pkg::LIM_X4 : qrsbd_pkg::LIM_X2;
  assign lg  = factor_sel_q ? qrsbd_pkg::LOG2_X4 : qrsbd_pkg::LOG2_X2;
  assign sh  = (sample_bits_q < lim) ? '0 : sample_bits_q - lim;

  always_comb begin
    case (k)
      2'd0: begin
        push_entry_o.rot_i = ri;
        push_entry_o.rot_q = rq;
      end
      2'd1: begin
        push_entry_o.rot_i = -rq;
        push_entry_o.rot_q = ri;
      end
      2'd2: begin
        push_entry_o.rot_i = -ri;
        push_entry_o.rot_q = -rq;
      end
      default: begin
        push_entry_o.rot_i = rq;
        push_entry_o.rot_q = -ri;
      end
    endcase
    push_entry_o.emit     = (phase_q == 2'd3) | (~factor_sel_q & (phase_q == 2'd1));
    push_entry_o.shift    = sh;
    push_entry_o.out_bits = sample_bits_q + lg - sh;
  end

endmodule

// ===== hw/rtl/qrsbd_queue.sv =====
// ----------------------------------------------------------------------------
// qrsbd_queue
// Short register queue between front end and accumulator; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module qrsbd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  qrsbd_pkg::entry_t push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output qrsbd_pkg::entry_t pop_entry_o
);

  qrsbd_pkg::entry_t              mem_q [qrsbd_pkg::QDEPTH];
  logic [qrsbd_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [qrsbd_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                           push, pop;

  assign push_ready_o = count_q != qrsbd_pkg::QCNT_W'(qrsbd_pkg::QDEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_ready_i & pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == qrsbd_pkg::QPTR_W'(qrsbd_pkg::QDEPTH - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == qrsbd_pkg::QPTR_W'(qrsbd_pkg::QDEPTH - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= qrsbd_pkg::QCNT_W'(qrsbd_pkg::QDEPTH))
    else $error("queue count exceeds depth");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

// ===== hw/rtl/qrsbd_back.sv =====
// ----------------------------------------------------------------------------
// qrsbd_back
// Accumulates rotated samples, shifts the group sum and holds the result in
// an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module qrsbd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  qrsbd_pkg::entry_t pop_entry_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [qrsbd_pkg::SAMPLE_W-1:0] out_i_o,
  output logic signed [qrsbd_pkg::SAMPLE_W-1:0] out_q_o,
  output logic [qrsbd_pkg::BITS_W-1:0]          out_bits_o
);

  logic signed [qrsbd_pkg::ACC_W-1:0] acc_i_q, acc_q_q;
  logic signed [qrsbd_pkg::ACC_W-1:0] sum_i, sum_q, shr_i, shr_q;
  logic                               out_valid_q;
  logic                               slot_free, pop;

  assign slot_free   = ~out_valid_q | out_ready_i;
  // Samples that do not close a group never wait on the output register.
  assign pop_ready_o = ~pop_entry_i.emit | slot_free;
  assign pop         = pop_valid_i & pop_ready_o;

  assign sum_i = acc_i_q + qrsbd_pkg::ACC_W'(pop_entry_i.rot_i);
  assign sum_q = acc_q_q + qrsbd_pkg::ACC_W'(pop_entry_i.rot_q);
  assign shr_i = sum_i >>> pop_entry_i.shift;
  assign shr_q = sum_q >>> pop_entry_i.shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_i_q     <= '0;
      acc_q_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (pop_entry_i.emit) begin
          acc_i_q <= '0;
          acc_q_q <= '0;
        end else begin
          acc_i_q <= sum_i;
          acc_q_q <= sum_q;
        end
      end
      if (pop && pop_entry_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && pop_entry_i.emit) begin
      out_i_o    <= shr_i[qrsbd_pkg::SAMPLE_W-1:0];
      out_q_o    <= shr_q[qrsbd_pkg::SAMPLE_W-1:0];
      out_bits_o <= pop_entry_i.out_bits;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && pop_entry_i.emit) |=> (acc_i_q == '0 && acc_q_q == '0 && out_valid_q))
    else $error("group close did not clear accumulator");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(pop && pop_entry_i.emit))
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== hw/rtl/quarter_rate_shift_boxcar_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// quarter_rate_shift_boxcar_decimator_unit
// Shifts a complex stream by a quarter of the sample rate and decimates it
// by 2 or 4 with a boxcar sum.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one I/Q sample per item; m_axis carries one decimated
//   sample per 2 or 4 input items. A trailing partial group is kept in the
//   accumulator and never flushed.
//   The cfg channel writes sample_bits (index 0), factor_sel (1) and
//   band_sel (2); it is always ready. Write it only while the stream is idle.
// Result path: the sample closing a group is written into a queue slot at
//   the edge that accepts it; when it is popped, the shifted group sum is
//   loaded into the output register, which drives m_axis_tvalid.
// Throughput: one input item per cycle while the queue has room; front end,
//   queue and accumulator each take one item per cycle unless a stall holds them.
// Reset: phase, accumulators, queue and output valid clear; sample_bits
//   returns to 16, factor_sel and band_sel to 0.
// Stall: the output register holds its result while m_axis_tready is low;
//   samples that do not close a group keep draining into the accumulator,
//   and the two-entry queue backs up into s_axis_tready once it is full.
// ----------------------------------------------------------------------------
module quarter_rate_shift_boxcar_decimator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qrsbd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qrsbd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [qrsbd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // in_i, in_q
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [qrsbd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // out_i, out_q, out_bits, zero pad
);

  logic              push_valid, push_ready, pop_valid, pop_ready;
  qrsbd_pkg::entry_t push_entry, pop_entry;
  logic signed [qrsbd_pkg::SAMPLE_W-1:0] out_i, out_q;
  logic [qrsbd_pkg::BITS_W-1:0]          out_bits;

  qrsbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_i_i       (s_axis_tdata[qrsbd_pkg::SAMPLE_W-1:0]),
    .in_q_i       (s_axis_tdata[2*qrsbd_pkg::SAMPLE_W-1:qrsbd_pkg::SAMPLE_W]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  qrsbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  qrsbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_i_o     (out_i),
    .out_q_o     (out_q),
    .out_bits_o  (out_bits)
  );

  assign m_axis_tdata = {{(qrsbd_pkg::OUT_TDATA_W - qrsbd_pkg::OUT_FIELD_W){1'b0}},
                         out_bits, out_q, out_i};

endmodule
